>>> sv/button_debounce_long_press_top_assert.svh
// Assertion macros for the button debounce block.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BDLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define BDLP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BDLP_ASSERT(lbl, prop, msg)
`define BDLP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> sv/bdlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdlp_pkg;

    localparam int MAX_BUTTONS = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [2:0] CFG_DEBOUNCE_ENABLE = 3'd0;
    localparam logic [2:0] CFG_PRESSED_LEVEL   = 3'd1;
    localparam logic [2:0] CFG_TIMER_MODE      = 3'd2;
    localparam logic [2:0] CFG_DEBOUNCE_MS     = 3'd3;
    localparam logic [2:0] CFG_LONG_PRESS_MS   = 3'd4;

    typedef struct packed {
        logic        func;
        logic [2:0]  line;
        logic        falling;
        logic [31:0] time_ms;
    } t_in;

    typedef struct packed {
        logic [2:0]  button;
        logic        is_long;
        logic [31:0] event_time_ms;
        logic        last;
    } t_out;

    typedef struct packed {
        logic        debounce_enable;
        logic        pressed_level;
        logic        timer_mode;
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        debounce_enable: 1'b1,
        pressed_level:   1'b0,
        timer_mode:      1'b1,
        debounce_ms:     16'd30,
        long_press_ms:   16'd1000
    };

    typedef struct packed {
        logic [MAX_BUTTONS-1:0] mask;
        logic                   is_long;
        logic [31:0]            time_ms;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

>>> sv/bdlp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bdlp_front #(
    parameter int NUM_BUTTONS = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire bdlp_pkg::t_in i_data,
    input  wire bdlp_pkg::t_cfg i_cfg,
    output logic               o_push,
    output bdlp_pkg::t_cmd     o_cmd
);

    logic [31:0]            r_press_start [NUM_BUTTONS];
    logic [31:0]            r_last_edge   [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_held;
    logic [NUM_BUTTONS-1:0] r_long_rep;

    logic                   w_is_tick;
    logic                   w_press;
    logic [NUM_BUTTONS-1:0] w_long;
    logic [NUM_BUTTONS-1:0] w_edge_hit;
    logic [NUM_BUTTONS-1:0] w_rel_ev;
    logic [NUM_BUTTONS-1:0] w_tick_hit;

    assign w_is_tick = (i_data.func == bdlp_pkg::FUNC_TICK);
    assign w_press   = ((~i_data.falling) == i_cfg.pressed_level);

    always_comb begin
        logic [31:0] v_diff_edge;
        logic [31:0] v_diff_press;
        logic        v_bounce;
        logic        v_sel;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            v_diff_edge  = i_data.time_ms - r_last_edge[i];
            v_diff_press = i_data.time_ms - r_press_start[i];
            v_sel        = (i_data.line == 3'(i));
            v_bounce     = i_cfg.debounce_enable && (r_last_edge[i] != 32'd0) &&
                           (v_diff_edge < {16'd0, i_cfg.debounce_ms});
            w_long[i]     = (v_diff_press >= {16'd0, i_cfg.long_press_ms});
            w_edge_hit[i] = i_accept && !w_is_tick && v_sel && !v_bounce;
            w_rel_ev[i]   = w_edge_hit[i] && !w_press && r_held[i] &&
                            (!i_cfg.timer_mode || !r_long_rep[i]);
            w_tick_hit[i] = i_accept && w_is_tick && i_cfg.timer_mode && r_held[i] &&
                            !r_long_rep[i] && w_long[i];
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.time_ms = i_data.time_ms;
        if (w_is_tick) begin
            o_cmd.mask[NUM_BUTTONS-1:0] = w_tick_hit;
            o_cmd.is_long               = 1'b1;
        end else begin
            o_cmd.mask[NUM_BUTTONS-1:0] = w_rel_ev;
            o_cmd.is_long               = !i_cfg.timer_mode && (|(w_rel_ev & w_long));
        end
        o_push = |o_cmd.mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_long_rep <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_last_edge[i] <= 32'd0;
            end
        end else begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                if (w_edge_hit[i]) begin
                    r_last_edge[i] <= i_data.time_ms;
                    if (w_press) begin
                        r_held[i]     <= 1'b1;
                        r_long_rep[i] <= 1'b0;
                    end else if (r_held[i]) begin
                        r_held[i] <= 1'b0;
                        if (i_cfg.timer_mode) begin
                            r_long_rep[i] <= 1'b0;
                        end
                    end
                end
                if (w_tick_hit[i]) begin
                    r_long_rep[i] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (w_edge_hit[i] && w_press) begin
                r_press_start[i] <= i_data.time_ms;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/bdlp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bdlp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire bdlp_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output bdlp_pkg::t_cmd      o_head,
    output bdlp_pkg::t_q_status o_status
);

    bdlp_pkg::t_cmd                      r_mem [bdlp_pkg::QUEUE_DEPTH];
    logic [bdlp_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr;
    logic [bdlp_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr;
    logic [bdlp_pkg::QUEUE_PTR_W:0]      r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == (bdlp_pkg::QUEUE_PTR_W + 1)'(bdlp_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> sv/bdlp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bdlp_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bdlp_pkg::t_cmd      i_head,
    input  wire bdlp_pkg::t_q_status i_q_status,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output bdlp_pkg::t_out           o_data
);

    logic [bdlp_pkg::MAX_BUTTONS-1:0] r_sent;
    logic                             r_valid;
    bdlp_pkg::t_out                   r_out;

    logic [bdlp_pkg::MAX_BUTTONS-1:0] w_rem;
    logic [bdlp_pkg::MAX_BUTTONS-1:0] w_pick;
    logic [bdlp_pkg::MAX_BUTTONS-1:0] w_rest;
    logic [2:0]                       w_button;
    logic                             w_load;

    assign w_rem  = i_head.mask & ~r_sent;
    assign w_pick = w_rem & (~w_rem + 1'b1);
    assign w_rest = w_rem & ~w_pick;
    assign w_load = !i_q_status.empty && (!r_valid || !i_stall);
    assign o_pop  = w_load && (w_rest == '0);

    always_comb begin
        w_button = 3'd0;
        for (int i = 0; i < bdlp_pkg::MAX_BUTTONS; i++) begin
            if (w_pick[i]) begin
                w_button = w_button | 3'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent  <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_sent  <= (w_rest == '0) ? '0 : (r_sent | w_pick);
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.button        <= w_button;
            r_out.is_long       <= i_head.is_long;
            r_out.event_time_ms <= i_head.time_ms;
            r_out.last          <= (w_rest == '0);
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

>>> sv/button_debounce_long_press_top.sv
// Latency: an item that causes events is written into the request queue, and its first event
// is registered at the output; events leave one per cycle when the output is not stalled.
// Throughput: one input item per cycle while the queue is not full; a tick causing k events
// go out one at a time; a four-entry request queue absorbs the difference before input stalls.
// Reset: synchronous, active low; clears queue, held and edge state, loads default config.
`timescale 1ns / 1ps
`default_nettype none
`include "button_debounce_long_press_top_assert.svh"

module button_debounce_long_press_top #(
    parameter int NUM_BUTTONS = 3
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire bdlp_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output bdlp_pkg::t_out      o_data,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [15:0]    i_cfg_data
);

    bdlp_pkg::t_cfg      r_cfg;
    bdlp_pkg::t_cmd      w_cmd;
    bdlp_pkg::t_cmd      w_head;
    bdlp_pkg::t_q_status w_q_status;
    logic                w_push;
    logic                w_pop;
    logic                w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = w_q_status.full;
    assign w_accept    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= bdlp_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bdlp_pkg::CFG_DEBOUNCE_ENABLE: r_cfg.debounce_enable <= i_cfg_data[0];
                bdlp_pkg::CFG_PRESSED_LEVEL:   r_cfg.pressed_level   <= i_cfg_data[0];
                bdlp_pkg::CFG_TIMER_MODE:      r_cfg.timer_mode      <= i_cfg_data[0];
                bdlp_pkg::CFG_DEBOUNCE_MS:     r_cfg.debounce_ms     <= i_cfg_data;
                bdlp_pkg::CFG_LONG_PRESS_MS:   r_cfg.long_press_ms   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bdlp_front #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_data   (i_data),
        .i_cfg    (r_cfg),
        .o_push   (w_push),
        .o_cmd    (w_cmd)
    );

    bdlp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    bdlp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

    `BDLP_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_valid, "output valid after reset")
    `BDLP_ASSERT(a_no_overflow, !(w_push && w_q_status.full), "request queue overflow")
    `BDLP_ASSERT(a_no_underflow, w_pop |-> !w_q_status.empty, "request queue underflow")
    `BDLP_ASSERT(a_burst_continues, o_valid && !o_data.last && !i_stall |=> o_valid, "event burst broken")

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bdlp_pkg::*;

    localparam int NUM_BUTTONS = 3;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out        o_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    t_in  pending_requests[$];
    t_out expected_events[$];
    int   queued_total = 0;
    int   error_count = 0;

    t_cfg        plan_cfg = CFG_RESET;
    logic [31:0] clock_ms = '0;
    logic        no_idle = 1'b0;
    logic        rx_hold_go = 1'b0;
    logic        rx_long_hold = 1'b0;

    t_cfg        live_cfg = CFG_RESET;
    logic [31:0] press_time [NUM_BUTTONS];
    logic [31:0] last_edge_time [NUM_BUTTONS];
    logic        btn_held [NUM_BUTTONS];
    logic        long_flagged [NUM_BUTTONS];

    int tx_gap = 0;
    int rx_gap = 0;

    button_debounce_long_press_top #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin : clock_gen
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic predict_events(input t_in req);
        t_out        found [NUM_BUTTONS];
        int          n;
        logic [31:0] since;
        logic [2:0]  b;
        logic        level;
        n = 0;
        if (req.func == FUNC_TICK) begin
            if (live_cfg.timer_mode) begin
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    since = req.time_ms - press_time[i];
                    if (btn_held[i] && !long_flagged[i] && since >= live_cfg.long_press_ms) begin
                        long_flagged[i] = 1'b1;
                        found[n] = '{button: 3'(i), is_long: 1'b1,
                                     event_time_ms: req.time_ms, last: 1'b0};
                        n++;
                    end
                end
            end
        end else if (req.line < NUM_BUTTONS) begin
            b = req.line;
            since = req.time_ms - last_edge_time[b];
            if (!(live_cfg.debounce_enable && last_edge_time[b] != 0 &&
                  since < live_cfg.debounce_ms)) begin
                last_edge_time[b] = req.time_ms;
                level = ~req.falling;
                since = req.time_ms - press_time[b];
                if (level == live_cfg.pressed_level) begin
                    btn_held[b] = 1'b1;
                    press_time[b] = req.time_ms;
                    long_flagged[b] = 1'b0;
                end else if (btn_held[b]) begin
                    btn_held[b] = 1'b0;
                    if (!live_cfg.timer_mode) begin
                        found[0] = '{button: b, is_long: since >= live_cfg.long_press_ms,
                                     event_time_ms: req.time_ms, last: 1'b0};
                        n = 1;
                    end else begin
                        if (!long_flagged[b]) begin
                            found[0] = '{button: b, is_long: 1'b0,
                                         event_time_ms: req.time_ms, last: 1'b0};
                            n = 1;
                        end
                        long_flagged[b] = 1'b0;
                    end
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            found[k].last = (k == n - 1);
            expected_events.push_back(found[k]);
        end
    endtask

    always @(posedge i_clk) begin : request_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap = 0;
        end else if (!i_valid || !o_stall) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (pending_requests.size() == 0) begin
                i_valid <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                tx_gap = $urandom_range(0, 14);
                i_valid <= 1'b0;
            end else begin
                i_data <= pending_requests.pop_front();
                i_valid <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : event_monitor
        t_out want;
        logic rx_idle;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_gap = 0;
            live_cfg = CFG_RESET;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                press_time[i] = '0;
                last_edge_time[i] = '0;
                btn_held[i] = 1'b0;
                long_flagged[i] = 1'b0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEBOUNCE_ENABLE: live_cfg.debounce_enable = i_cfg_data[0];
                    CFG_PRESSED_LEVEL:   live_cfg.pressed_level = i_cfg_data[0];
                    CFG_TIMER_MODE:      live_cfg.timer_mode = i_cfg_data[0];
                    CFG_DEBOUNCE_MS:     live_cfg.debounce_ms = i_cfg_data;
                    CFG_LONG_PRESS_MS:   live_cfg.long_press_ms = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                predict_events(i_data);
            end
            if (o_valid && !i_stall) begin
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected event button %0d long %0b t %0d",
                                              o_data.button, o_data.is_long,
                                              o_data.event_time_ms));
                end else begin
                    want = expected_events.pop_front();
                    if (o_data.button !== want.button)
                        report_mismatch($sformatf("button got %0d want %0d",
                                                  o_data.button, want.button));
                    if (o_data.is_long !== want.is_long)
                        report_mismatch($sformatf("is_long got %0b want %0b",
                                                  o_data.is_long, want.is_long));
                    if (o_data.event_time_ms !== want.event_time_ms)
                        report_mismatch($sformatf("event_time_ms got %0d want %0d",
                                                  o_data.event_time_ms, want.event_time_ms));
                    if (o_data.last !== want.last)
                        report_mismatch($sformatf("last got %0b want %0b",
                                                  o_data.last, want.last));
                end
            end
            if (rx_gap > 0) begin
                rx_gap--;
                rx_idle = 1'b1;
            end else if (!no_idle && $urandom_range(0, 11) == 0) begin
                rx_gap = $urandom_range(0, 14);
                rx_idle = 1'b1;
            end else begin
                rx_idle = 1'b0;
            end
            i_stall <= rx_idle || rx_long_hold;
        end
    end

    initial begin : rx_long_hold_ctrl
        wait (rx_hold_go);
        @(posedge i_clk);
        rx_long_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        rx_long_hold <= 1'b0;
    end

    initial begin : watchdog
        int stuck_cycles;
        stuck_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("ERROR: no handshake for %0d cycles", STUCK_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    function automatic void queue_edge(input int btn, input bit is_press, input logic [31:0] t);
        t_in req;
        req.func = FUNC_EDGE;
        req.line = 3'(btn);
        req.falling = is_press ? ~plan_cfg.pressed_level : plan_cfg.pressed_level;
        req.time_ms = t;
        pending_requests.push_back(req);
        queued_total++;
    endfunction

    function automatic void queue_tick(input logic [31:0] t);
        t_in req;
        req.func = FUNC_TICK;
        req.line = 3'($urandom_range(0, 7));
        req.falling = 1'($urandom_range(0, 1));
        req.time_ms = t;
        pending_requests.push_back(req);
        queued_total++;
    endfunction

    function automatic void queue_press_sequence(input bit with_bounce);
        logic [2:0] mask;
        int         deb;
        int         lng;
        int         first_btn;
        deb = plan_cfg.debounce_ms;
        lng = plan_cfg.long_press_ms;
        mask = 3'($urandom_range(1, 7));
        first_btn = -1;
        clock_ms += deb + $urandom_range(1, 20);
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (mask[b]) begin
                if (first_btn < 0)
                    first_btn = b;
                queue_edge(b, 1'b1, clock_ms);
                clock_ms += $urandom_range(0, 3);
            end
        end
        if (with_bounce) begin
            queue_edge(first_btn, 1'b0, clock_ms + $urandom_range(0, 2));
            queue_edge(first_btn, 1'b1, clock_ms + $urandom_range(2, 4));
        end
        repeat ($urandom_range(0, 3)) begin
            clock_ms += $urandom_range(0, lng / 2 + 20);
            queue_tick(clock_ms);
        end
        clock_ms += deb + $urandom_range(0, lng + 20);
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (mask[b]) begin
                queue_edge(b, 1'b0, clock_ms);
                clock_ms += $urandom_range(0, 3);
            end
        end
    endfunction

    task automatic queue_random_requests(input int count);
        int  target;
        int  kind;
        t_in req;
        target = queued_total + count;
        while (queued_total < target) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                queue_press_sequence(1'b0);
            end else if (kind < 8) begin
                queue_press_sequence(1'b1);
            end else begin
                req.func = 1'($urandom_range(0, 1));
                req.line = 3'($urandom_range(0, 7));
                req.falling = 1'($urandom_range(0, 1));
                req.time_ms = $urandom;
                pending_requests.push_back(req);
                queued_total++;
            end
        end
    endtask

    function automatic t_cfg random_config(input logic timer_mode);
        t_cfg c;
        c.debounce_enable = 1'b1;
        c.pressed_level = 1'($urandom_range(0, 1));
        c.timer_mode = timer_mode;
        c.debounce_ms = 16'($urandom_range(0, 120));
        c.long_press_ms = 16'($urandom_range(40, 2500));
        return c;
    endfunction

    task automatic load_config(input t_cfg c);
        logic [2:0]  reg_index [5];
        logic [15:0] reg_value [5];
        reg_index[0] = CFG_DEBOUNCE_ENABLE;
        reg_value[0] = {15'd0, c.debounce_enable};
        reg_index[1] = CFG_PRESSED_LEVEL;
        reg_value[1] = {15'd0, c.pressed_level};
        reg_index[2] = CFG_TIMER_MODE;
        reg_value[2] = {15'd0, c.timer_mode};
        reg_index[3] = CFG_DEBOUNCE_MS;
        reg_value[3] = c.debounce_ms;
        reg_index[4] = CFG_LONG_PRESS_MS;
        reg_value[4] = c.long_press_ms;
        plan_cfg = c;
        for (int k = 0; k < 5; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_index[k];
            i_cfg_data <= reg_value[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || i_valid || expected_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_cfg c;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default settings: press is a falling edge, timer mode, 30 ms debounce, 1000 ms long.
        plan_cfg = CFG_RESET;
        queue_edge(0, 1'b1, 32'd0);
        queue_edge(0, 1'b0, 32'd5);
        queue_edge(0, 1'b1, 32'd10);
        queue_edge(7, 1'b1, 32'd100);
        queue_edge(3, 1'b0, 32'd100);
        queue_edge(1, 1'b0, 32'd100);
        queue_edge(1, 1'b1, 32'd200);
        queue_edge(1, 1'b1, 32'd300);
        queue_edge(2, 1'b1, 32'd300);
        queue_edge(0, 1'b1, 32'd400);
        queue_tick(32'd1299);
        queue_tick(32'd1300);
        queue_tick(32'd1400);
        queue_edge(1, 1'b0, 32'd1500);
        queue_edge(1, 1'b1, 32'd1600);
        queue_edge(0, 1'b1, 32'd1600);
        queue_edge(2, 1'b1, 32'd1600);
        queue_tick(32'd2600);
        queue_edge(0, 1'b0, 32'd2700);
        queue_edge(2, 1'b0, 32'd2700);
        queue_edge(1, 1'b0, 32'd2700);
        queue_edge(1, 1'b1, 32'hFFFF_FFC0);
        queue_edge(1, 1'b0, 32'hFFFF_FFFF);
        queue_edge(1, 1'b1, 32'h0000_0010);
        queue_edge(2, 1'b1, 32'h0000_0020);
        queue_tick(32'h0000_0408);
        wait_drained();

        c = '{debounce_enable: 1'b0, pressed_level: 1'b1, timer_mode: 1'b0,
              debounce_ms: 16'd0, long_press_ms: 16'd0};
        load_config(c);
        clock_ms = $urandom_range(1, 1000);
        queue_random_requests(18);
        wait_drained();

        c = '{debounce_enable: 1'b1, pressed_level: 1'b0, timer_mode: 1'b1,
              debounce_ms: 16'hFFFF, long_press_ms: 16'hFFFF};
        load_config(c);
        clock_ms = 32'hFFFE_8000;
        queue_random_requests(18);
        wait_drained();

        // The receiver holds off for a long stretch while requests keep coming.
        load_config(random_config(1'b0));
        rx_hold_go = 1'b1;
        queue_random_requests(24);
        wait_drained();

        no_idle = 1'b1;
        load_config(random_config(1'b1));
        queue_random_requests(18);
        wait_drained();

        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
